[hdl/per_address_rate_limiter_top_assert.svh]
// Assertion macros for the per-address rate limiter.
// Included by modules that check their own control logic; no other dependencies.
`ifndef PER_ADDRESS_RATE_LIMITER_TOP_ASSERT_SVH
`define PER_ADDRESS_RATE_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PARL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PARL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/parl_pkg.sv]
// Shared types and constants for the per-address rate limiter.
// No dependencies; used by the interfaces and the top-level module.
package parl_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W    = 128;
  localparam int HALF_W   = 64;
  localparam int CREDIT_W = 16;
  localparam int TIME_W   = 32;
  localparam int WIN_W    = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'b1;

  localparam logic [CREDIT_W-1:0] DEFAULT_LIMIT_RST  = 16'd1000;
  localparam logic [WIN_W-1:0]    WINDOW_SECONDS_RST = 16'd3600;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic CMD_QUERY   = 1'b0;
  localparam logic CMD_CONSUME = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISSED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [CREDIT_W-1:0] credit;
    logic [TIME_W-1:0]   deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/parl_if.sv]
// Request and result channel interfaces (valid/ready) for the rate limiter.
// Depends on parl_pkg for field widths.
interface parl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [parl_pkg::HALF_W-1:0]   addr_high;
  logic [parl_pkg::HALF_W-1:0]   addr_low;
  logic [parl_pkg::TIME_W-1:0]   now_seconds;

  modport source (output valid, command, addr_high, addr_low, now_seconds, input ready);
  modport sink   (input valid, command, addr_high, addr_low, now_seconds, output ready);
endinterface

interface parl_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [parl_pkg::CREDIT_W-1:0] remaining;
  logic [parl_pkg::TIME_W-1:0]   reset_time;

  modport source (output valid, status, remaining, reset_time, input ready);
  modport sink   (input valid, status, remaining, reset_time, output ready);
endinterface

[hdl/parl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module parl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic [AW-1:0]             raddr,
  output logic [WIDTH-1:0]          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[hdl/per_address_rate_limiter_top.sv]
// Top level of the per-address fixed-window rate limiter.
// Depends on parl_pkg, parl_if.sv, parl_ram and per_address_rate_limiter_top_assert.svh.
//
// Usage:
//   in_req  : request channel (valid/ready). command 0 queries an address and
//             refills an expired window or inserts a new entry; command 1
//             consumes one credit of a known address.
//   out_rsp : result channel (valid/ready), one result per request:
//             status, remaining credit and window end time.
//   cfg_*   : write-only register port: index 0 default_limit, index 1
//             window_seconds. Write only while no request is in flight.
// Timing:
//   One request at a time: the next is accepted once the previous one has left
//   the write-back state. Each request scans n entries, n being 0 on an empty
//   table, else 1 up to the fill count. The scan reads the entry RAM one address
//   per cycle; the write-back state then loads the result into the output register.
// Reset (rst_n low, synchronous): table empty, registers at 1000 / 3600,
//   no result pending. Table RAM contents are not cleared; only entries below
//   the fill count are ever compared.
// Stall: the output register holds a result until taken; the next request is
//   accepted and scanned meanwhile, and the block waits in its write-back
//   cycle until the output register is free.
`include "per_address_rate_limiter_top_assert.svh"

module per_address_rate_limiter_top (
  input  logic                             clk,
  input  logic                             rst_n,
  parl_in_if.sink                          in_req,
  parl_out_if.source                       out_rsp,
  input  logic                             cfg_we,
  input  logic [parl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [parl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Control state
  parl_pkg::state_t               state_r, state_nxt;
  logic [parl_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [parl_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                           hit_r, hit_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // Configuration registers
  logic [parl_pkg::CREDIT_W-1:0]  default_limit_r;
  logic [parl_pkg::WIN_W-1:0]     window_seconds_r;

  // Request and matched-entry payload
  logic                           cmd_r;
  logic [parl_pkg::KEY_W-1:0]     key_r;
  logic [parl_pkg::TIME_W-1:0]    now_r;
  logic [parl_pkg::IDX_W-1:0]     slot_r;
  logic [parl_pkg::CREDIT_W-1:0]  cred_r;
  logic [parl_pkg::TIME_W-1:0]    dl_r;

  // Result register
  parl_pkg::status_t              status_r, status_nxt;
  logic [parl_pkg::CREDIT_W-1:0]  remaining_r, remaining_nxt;
  logic [parl_pkg::TIME_W-1:0]    reset_time_r, reset_time_nxt;

  // RAM ports
  logic                           ram_we;
  logic [parl_pkg::IDX_W-1:0]     ram_waddr;
  parl_pkg::entry_t               ram_wdata;
  logic [parl_pkg::IDX_W-1:0]     ram_raddr;
  parl_pkg::entry_t               ram_rdata;

  logic                           accept;
  logic                           match;
  logic                           last_scan;
  logic                           out_free;
  logic                           expired;
  logic                           full;
  logic [parl_pkg::TIME_W:0]      end_sum;
  logic [parl_pkg::TIME_W-1:0]    end_sat;

  parl_ram #(
    .WIDTH (parl_pkg::ENTRY_W),
    .DEPTH (parl_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_req.ready      = (state_r == parl_pkg::S_IDLE);
  assign accept            = in_req.valid && in_req.ready;
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = status_r;
  assign out_rsp.remaining = remaining_r;
  assign out_rsp.reset_time = reset_time_r;
  assign out_free          = !out_valid_r || out_rsp.ready;

  // Read address runs one ahead of the compare: data for idx_r is in ram_rdata.
  assign ram_raddr = (state_r == parl_pkg::S_IDLE) ? '0 : idx_r + parl_pkg::IDX_W'(1);
  assign match     = (ram_rdata.key == key_r);
  assign last_scan = (parl_pkg::CNT_W'(idx_r) + parl_pkg::CNT_W'(1)) == count_r;

  // Window arithmetic for the refill
  assign expired = dl_r < now_r;
  assign end_sum = {1'b0, now_r} + (parl_pkg::TIME_W + 1)'(window_seconds_r);
  assign end_sat = end_sum[parl_pkg::TIME_W] ? parl_pkg::TIME_MAX
                                              : end_sum[parl_pkg::TIME_W-1:0];
  assign full    = (count_r == parl_pkg::CNT_W'(parl_pkg::TABLE_DEPTH));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    status_nxt     = status_r;
    remaining_nxt  = remaining_r;
    reset_time_nxt = reset_time_r;
    ram_we         = 1'b0;
    ram_waddr      = slot_r;
    ram_wdata      = '{key: key_r, credit: cred_r, deadline: dl_r};

    unique case (state_r)
      parl_pkg::S_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = (count_r == '0) ? parl_pkg::S_UPDATE : parl_pkg::S_SEARCH;
        end
      end
      parl_pkg::S_SEARCH: begin
        if (match) begin
          hit_nxt   = 1'b1;
          state_nxt = parl_pkg::S_UPDATE;
        end else if (last_scan) begin
          state_nxt = parl_pkg::S_UPDATE;
        end else begin
          idx_nxt = idx_r + parl_pkg::IDX_W'(1);
        end
      end
      parl_pkg::S_UPDATE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = parl_pkg::S_IDLE;
          if (cmd_r == parl_pkg::CMD_QUERY) begin
            if (hit_r) begin
              status_nxt     = parl_pkg::ST_FOUND;
              remaining_nxt  = expired ? default_limit_r : cred_r;
              reset_time_nxt = expired ? end_sat : dl_r;
              ram_we         = expired;
              ram_wdata      = '{key: key_r, credit: default_limit_r, deadline: end_sat};
            end else if (!full) begin
              // Append at the fill position
              status_nxt     = parl_pkg::ST_INSERTED;
              remaining_nxt  = default_limit_r;
              reset_time_nxt = '0;
              ram_we         = 1'b1;
              ram_waddr      = count_r[parl_pkg::IDX_W-1:0];
              ram_wdata      = '{key: key_r, credit: default_limit_r, deadline: '0};
              count_nxt      = count_r + parl_pkg::CNT_W'(1);
            end else begin
              status_nxt     = parl_pkg::ST_FULL;
              remaining_nxt  = default_limit_r;
              reset_time_nxt = '0;
            end
          end else begin
            if (hit_r) begin
              status_nxt     = parl_pkg::ST_FOUND;
              remaining_nxt  = (cred_r != '0) ? cred_r - parl_pkg::CREDIT_W'(1) : '0;
              reset_time_nxt = dl_r;
              ram_we         = 1'b1;
              ram_wdata      = '{key: key_r, credit: remaining_nxt, deadline: dl_r};
            end else begin
              status_nxt     = parl_pkg::ST_MISSED;
              remaining_nxt  = '0;
              reset_time_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = parl_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= parl_pkg::S_IDLE;
      count_r          <= '0;
      idx_r            <= '0;
      hit_r            <= 1'b0;
      out_valid_r      <= 1'b0;
      default_limit_r  <= parl_pkg::DEFAULT_LIMIT_RST;
      window_seconds_r <= parl_pkg::WINDOW_SECONDS_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          parl_pkg::CFG_DEFAULT_LIMIT:  default_limit_r  <= cfg_wdata;
          parl_pkg::CFG_WINDOW_SECONDS: window_seconds_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_req.command;
      key_r <= {in_req.addr_high, in_req.addr_low};
      now_r <= in_req.now_seconds;
    end
    if (state_r == parl_pkg::S_SEARCH && match) begin
      slot_r <= idx_r;
      cred_r <= ram_rdata.credit;
      dl_r   <= ram_rdata.deadline;
    end
    status_r     <= status_nxt;
    remaining_r  <= remaining_nxt;
    reset_time_r <= reset_time_nxt;
  end

  // Checks
  `PARL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
    count_r <= parl_pkg::CNT_W'(parl_pkg::TABLE_DEPTH), "fill count above table depth")
  `PARL_ASSERT_NOW(a_scan_in_range, clk, rst_n, state_r == parl_pkg::S_SEARCH,
    parl_pkg::CNT_W'(idx_r) < count_r, "scan index past fill count")
  `PARL_ASSERT_NOW(a_write_in_update, clk, rst_n, ram_we,
    state_r == parl_pkg::S_UPDATE && out_free, "table write outside write-back")
  `PARL_ASSERT_NEXT(a_insert_counts, clk, rst_n,
    state_r == parl_pkg::S_UPDATE && out_free && status_nxt == parl_pkg::ST_INSERTED,
    count_r == $past(count_r) + parl_pkg::CNT_W'(1), "insert without count step")
  `PARL_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_r && !out_rsp.ready,
    out_valid_r && $stable(status_r) && $stable(remaining_r), "stalled result changed")

endmodule
